FILE: rtl/scpb_pkg.sv
package scpb_pkg;

  // Pixel item as it enters the block.
  typedef struct packed {
    logic [11:0] pix_x;
    logic [11:0] pix_y;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [7:0]  in_alpha;
  } pix_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       inside_circle;
  } pix_out_t;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned SqrtStages = 8;
  localparam int unsigned DivStages  = 8;

  // Configuration register indexes.
  localparam logic [2:0] RegCenterX  = 3'd0;
  localparam logic [2:0] RegCenterY  = 3'd1;
  localparam logic [2:0] RegRadius   = 3'd2;
  localparam logic [2:0] RegColorRed = 3'd3;
  localparam logic [2:0] RegColorGrn = 3'd4;
  localparam logic [2:0] RegColorBlu = 3'd5;
  localparam logic [2:0] RegOpacity  = 3'd6;

  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] quo;
  } div_t;

  // One digit of the bitwise square root: brings in two radicand bits.
  function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] bits);
    logic [19:0] shifted;
    logic [19:0] trial;
    sqrt_t       nxt;
    shifted = {cur.rem, bits};
    trial   = {2'b00, cur.root, 2'b01};
    if (shifted >= trial) begin
      nxt.rem  = 18'(shifted - trial);
      nxt.root = {cur.root[14:0], 1'b1};
    end else begin
      nxt.rem  = shifted[17:0];
      nxt.root = {cur.root[14:0], 1'b0};
    end
    return nxt;
  endfunction

  // One digit of restoring division by an 8 bit divisor.
  function automatic div_t div_step(div_t cur, logic bit_in, logic [7:0] divisor);
    logic [8:0] shifted;
    div_t       nxt;
    shifted = {cur.rem, bit_in};
    if (shifted >= {1'b0, divisor}) begin
      nxt.rem = 8'(shifted - {1'b0, divisor});
      nxt.quo = {cur.quo[14:0], 1'b1};
    end else begin
      nxt.rem = shifted[7:0];
      nxt.quo = {cur.quo[14:0], 1'b0};
    end
    return nxt;
  endfunction

  // pix*(1-f) + col*f in Q0.16, truncated, written with one multiply.
  function automatic logic [7:0] mix(logic [7:0] pix, logic [7:0] col, logic [15:0] f);
    logic signed [8:0]  diff;
    logic signed [26:0] prod;
    logic signed [26:0] acc;
    diff = $signed({1'b0, col}) - $signed({1'b0, pix});
    prod = 27'(diff * $signed({1'b0, f}));
    acc  = $signed({3'b000, pix, 16'h0000}) + prod;
    return acc[23:16];
  endfunction

endpackage

FILE: rtl/scpb_root_div.sv
module scpb_root_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [15:0] d2_i,
  input  logic [7:0]  radius_i,
  output logic        valid_o,
  output logic [15:0] quo_o
);

  localparam int unsigned NSq  = scpb_pkg::SqrtStages;
  localparam int unsigned NDiv = scpb_pkg::DivStages;

  logic              sq_vld_q [NSq];
  scpb_pkg::sqrt_t   sq_st_q  [NSq];
  logic [15:0]       sq_d2_q  [NSq];
  logic              dv_vld_q [NDiv];
  scpb_pkg::div_t    dv_st_q  [NDiv];
  logic [15:0]       dv_low_q [NDiv];

  // Square root of d2 * 2^16, two result bits per stage.
  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    scpb_pkg::sqrt_t st_in;
    scpb_pkg::sqrt_t st_mid;
    scpb_pkg::sqrt_t st_d;
    logic [15:0]     d2_in;
    logic            vld_in;
    logic [3:0]      bits;

    if (k == 0) begin : g_first
      assign st_in  = '0;
      assign d2_in  = d2_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign st_in  = sq_st_q[k-1];
      assign d2_in  = sq_d2_q[k-1];
      assign vld_in = sq_vld_q[k-1];
    end

    if (k < 4) begin : g_hi
      assign bits = d2_in[15-4*k -: 4];
    end else begin : g_lo
      assign bits = 4'h0;
    end

    assign st_mid = scpb_pkg::sqrt_step(st_in, bits[3:2]);
    assign st_d   = scpb_pkg::sqrt_step(st_mid, bits[1:0]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else begin
        sq_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_st_q[k] <= st_d;
      sq_d2_q[k] <= d2_in;
    end
  end

  // Division (root << 8) / radius. For items inside the circle the root is
  // below 256 * radius, so the upper root byte is already a valid partial remainder.
  for (genvar j = 0; j < NDiv; j++) begin : g_div
    scpb_pkg::div_t st_in;
    scpb_pkg::div_t st_mid;
    scpb_pkg::div_t st_d;
    logic [15:0]    low_in;
    logic           vld_in;

    if (j == 0) begin : g_first
      assign st_in.rem = sq_st_q[NSq-1].root[15:8];
      assign st_in.quo = 16'h0000;
      assign low_in    = {sq_st_q[NSq-1].root[7:0], 8'h00};
      assign vld_in    = sq_vld_q[NSq-1];
    end else begin : g_next
      assign st_in  = dv_st_q[j-1];
      assign low_in = dv_low_q[j-1];
      assign vld_in = dv_vld_q[j-1];
    end

    assign st_mid = scpb_pkg::div_step(st_in, low_in[15-2*j], radius_i);
    assign st_d   = scpb_pkg::div_step(st_mid, low_in[14-2*j], radius_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else begin
        dv_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_st_q[j]  <= st_d;
      dv_low_q[j] <= low_in;
    end
  end

  assign valid_o = dv_vld_q[NDiv-1];
  assign quo_o   = dv_st_q[NDiv-1].quo;

endmodule

FILE: rtl/soft_circle_pixel_blend_unit.sv
// Soft circle pixel blend unit.
// Blends a soft-edged filled circle into a stream of RGBA pixels. Each input
// item (pix_i) carries a pixel's x,y position and its four channels; it is
// accepted at a rising edge where start is high and busy is low. busy is
// always low, so one item can be accepted in every clock cycle.
// Every item gives exactly one result item on res_o, shown for one cycle
// with res_valid_o high, once it has passed through the pipeline. The
// pipeline is 22 register stages: distance, squares, sum and compare, eight
// square root stages, eight division stages, two multiply stages and the
// final blend. The receiver cannot stall, so no item is ever held back.
// The circle is set through a separate write channel (cfg_valid_i,
// cfg_ready_o, cfg_index_i, cfg_data_i); cfg_ready_o is always high and a
// write to an index beyond the register list is ignored. Registers should
// only be written while no item is in flight.
// Reset clears the pipeline valid bits and returns the registers to their
// defaults: center 0,0, radius 30, black colour, opacity 6554.
module soft_circle_pixel_blend_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  scpb_pkg::pix_in_t   pix_i,
  output logic                res_valid_o,
  output scpb_pkg::pix_out_t  res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned SideDepth = scpb_pkg::SqrtStages + scpb_pkg::DivStages;

  // Payload that rides alongside the distance math.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       in_circle;
  } side_t;

  // Configuration registers.
  logic [11:0] center_x_q;
  logic [11:0] center_y_q;
  logic [7:0]  radius_q;
  logic [7:0]  col_r_q;
  logic [7:0]  col_g_q;
  logic [7:0]  col_b_q;
  logic [15:0] opacity_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= 12'd0;
      center_y_q <= 12'd0;
      radius_q   <= 8'd30;
      col_r_q    <= 8'd0;
      col_g_q    <= 8'd0;
      col_b_q    <= 8'd0;
      opacity_q  <= 16'd6554;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        scpb_pkg::RegCenterX:  center_x_q <= cfg_data_i[11:0];
        scpb_pkg::RegCenterY:  center_y_q <= cfg_data_i[11:0];
        scpb_pkg::RegRadius:   radius_q   <= cfg_data_i[7:0];
        scpb_pkg::RegColorRed: col_r_q    <= cfg_data_i[7:0];
        scpb_pkg::RegColorGrn: col_g_q    <= cfg_data_i[7:0];
        scpb_pkg::RegColorBlu: col_b_q    <= cfg_data_i[7:0];
        scpb_pkg::RegOpacity:  opacity_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: absolute distances and the frame bounds check.
  logic        s1_vld_q, s2_vld_q, s3_vld_q;
  logic [11:0] dx_q, dy_q;
  logic        s1_ok_q, s2_ok_q;
  scpb_pkg::pix_in_t s1_pix_q, s2_pix_q;
  logic        accept;
  logic [11:0] dx_d, dy_d;
  logic        ok_d;

  assign accept = start && !busy;
  assign dx_d = (pix_i.pix_x >= center_x_q) ? pix_i.pix_x - center_x_q
                                            : center_x_q - pix_i.pix_x;
  assign dy_d = (pix_i.pix_y >= center_y_q) ? pix_i.pix_y - center_y_q
                                            : center_y_q - pix_i.pix_y;
  assign ok_d = (32'(pix_i.pix_x) < 32'(scpb_pkg::MaxWidth)) &&
                (32'(pix_i.pix_y) < 32'(scpb_pkg::MaxHeight));

  // Stage 2: squares. Stage 3: sum and compare with radius squared.
  logic [23:0] dx2_q, dy2_q;
  logic [15:0] r2_q;
  logic [24:0] d2_sum;
  logic [15:0] d2_q;
  side_t       s3_side_q;

  assign d2_sum = {1'b0, dx2_q} + {1'b0, dy2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    s1_ok_q   <= ok_d;
    s1_pix_q  <= pix_i;
    dx2_q     <= dx_q * dx_q;
    dy2_q     <= dy_q * dy_q;
    r2_q      <= radius_q * radius_q;
    s2_ok_q   <= s1_ok_q;
    s2_pix_q  <= s1_pix_q;
    // A zero radius gives r2 of zero, so nothing is inside.
    d2_q                <= d2_sum[15:0];
    s3_side_q.red       <= s2_pix_q.in_red;
    s3_side_q.green     <= s2_pix_q.in_green;
    s3_side_q.blue      <= s2_pix_q.in_blue;
    s3_side_q.alpha     <= s2_pix_q.in_alpha;
    s3_side_q.in_circle <= s2_ok_q && (d2_sum < {9'd0, r2_q});
  end

  // Stages 4 to 19: distance over radius in Q0.16.
  logic        rd_vld;
  logic [15:0] quo;

  scpb_root_div u_root_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_vld_q),
    .d2_i     (d2_q),
    .radius_i (radius_q),
    .valid_o  (rd_vld),
    .quo_o    (quo)
  );

  // Side payload delay matching the root and division stages.
  side_t side_q [SideDepth];

  for (genvar i = 0; i < SideDepth; i++) begin : g_side
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        side_q[i] <= s3_side_q;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Stage 20: (1 - q)^2. Stage 21: times opacity. Stage 22: blend.
  logic        s20_vld_q, s21_vld_q, res_vld_q;
  logic [16:0] m;
  logic [33:0] mm;
  logic [16:0] sq_q;
  logic [32:0] fp;
  logic [15:0] f_q;
  side_t       s20_side_q, s21_side_q;
  scpb_pkg::pix_out_t res_q;

  assign m  = 17'h10000 - {1'b0, quo};
  assign mm = m * m;
  assign fp = sq_q * opacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s20_vld_q <= 1'b0;
      s21_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s20_vld_q <= rd_vld;
      s21_vld_q <= s20_vld_q;
      res_vld_q <= s21_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q       <= mm[32:16];
    s20_side_q <= side_q[SideDepth-1];
    f_q        <= fp[31:16];
    s21_side_q <= s20_side_q;
    res_q.out_alpha     <= s21_side_q.alpha;
    res_q.inside_circle <= s21_side_q.in_circle;
    if (s21_side_q.in_circle) begin
      res_q.out_red   <= scpb_pkg::mix(s21_side_q.red, col_r_q, f_q);
      res_q.out_green <= scpb_pkg::mix(s21_side_q.green, col_g_q, f_q);
      res_q.out_blue  <= scpb_pkg::mix(s21_side_q.blue, col_b_q, f_q);
    end else begin
      res_q.out_red   <= s21_side_q.red;
      res_q.out_green <= s21_side_q.green;
      res_q.out_blue  <= s21_side_q.blue;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/scpb_checker.sv
module scpb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input scpb_pkg::pix_in_t   pix_i,
  input logic                res_valid_o,
  input scpb_pkg::pix_out_t  res_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [2:0]          cfg_index_i,
  input logic [15:0]         cfg_data_i
);

  localparam int unsigned Latency = 22;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##22 res_valid_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, Latency))
    else $error("result without an accepted item");

  a_alpha_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.out_alpha == $past(pix_i.in_alpha, Latency))
    else $error("alpha changed");

  a_outside_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.inside_circle |->
      res_o.out_red == $past(pix_i.in_red, Latency) &&
      res_o.out_blue == $past(pix_i.in_blue, Latency))
    else $error("outside pixel was modified");

endmodule

bind soft_circle_pixel_blend_unit scpb_checker u_scpb_checker (.*);
